FILE: rtl/core/tspc_pkg.sv
// ----------------------------------------------------------------------------
// tspc_pkg: shared types and constants of the tri-allelic site pair classifier
// Field widths, stream bus widths and the front-to-back job.
// ----------------------------------------------------------------------------
package tspc_pkg;

    localparam int MaxContext  = 15;              // context bases carried per record
    localparam int ChromW      = 10;
    localparam int PosW        = 31;
    localparam int CountW      = 24;
    localparam int LenW        = 4;
    localparam int CtxW        = 3 * MaxContext;  // 3 bits per context base
    localparam int WinW        = 2 * MaxContext;  // 2 bits per window base
    localparam int InDataW     = 144;
    localparam int InUserW     = 3;
    localparam int OutDataW    = 144;
    localparam int QueueDepth  = 2;
    localparam int PtrW        = $clog2(QueueDepth);
    localparam int CntW        = $clog2(QueueDepth + 1);

    localparam logic [LenW-1:0] WindowReset = 4'd5;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;

    // one classified pair, handed from the front to the back
    typedef struct packed {
        logic [ChromW-1:0] chrom;
        logic [PosW-1:0]   pos;
        logic [WinW-1:0]   window;      // unfolded k-mer, zero above 2*wlen
        logic [LenW-1:0]   wlen;        // window length, never zero
        logic [1:0]        major;
        logic [1:0]        minor;
        logic [1:0]        prev_minor;
        logic [CountW-1:0] count;
        logic [CountW-1:0] prev_count;
    } tspc_job_t;

endpackage

FILE: rtl/core/triallelic_site_pair_classifier.sv
// ----------------------------------------------------------------------------
// triallelic_site_pair_classifier: pairs consecutive SNP records at one site
// Front filters and matches records, a two-entry queue decouples it from the
// back, which folds strands and sorts minor counts into result slots.
//
//   channel   direction  payload
//   s_        in         record: tdata 142 bits + 2 pad, tuser 3 flags
//   m_        out        tri-allelic site: tdata 144 bits
//   cfg_      in         window_bases, 4 bits
//
// One record per cycle in while the queue is not full.
// The front decides and updates the held record in the accept cycle, the
// back registers the result. s_tready drops only while the queue is full.
// Reset restores a window of 5 and empties the held record and the queue.
// ----------------------------------------------------------------------------
module triallelic_site_pair_classifier import tspc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // chrom_index, site_position, ref_base, alt_base, allele_count,
    // allele_number, context_length, context_bases, 2 zero bits
    input  logic [InDataW-1:0]  s_tdata,
    // is_single_base, counts_present, context_present
    input  logic [InUserW-1:0]  s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // chrom_out, position_out, window_out, major_base_out,
    // transition_count, second_count, third_count
    output logic [OutDataW-1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LenW-1:0]     cfg_data
);

    logic [LenW-1:0] window_reg;
    logic            full;
    logic            empty;
    logic            push;
    logic            pop;
    logic            in_accept;
    tspc_job_t       front_job;
    tspc_job_t       back_job;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    // window_bases register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WindowReset;
        end else if (cfg_valid && cfg_ready) begin
            window_reg <= cfg_data;
        end
    end

    tspc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .in_data      (s_tdata),
        .in_user      (s_tuser),
        .window_bases (window_reg),
        .push         (push),
        .job          (front_job)
    );

    tspc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (front_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .pop_job  (back_job)
    );

    tspc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .job      (back_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: rtl/core/tspc_front.sv
// ----------------------------------------------------------------------------
// tspc_front: record filter, allele folding and pair matching
// Holds the last usable record, cuts and checks the context window and
// pushes a job for every record that completes a tri-allelic pair.
// ----------------------------------------------------------------------------
module tspc_front import tspc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  logic [InDataW-1:0]  in_data,
    input  logic [InUserW-1:0]  in_user,
    input  logic [LenW-1:0]     window_bases,
    output logic                push,
    output tspc_job_t           job
);

    logic [ChromW-1:0] chrom;
    logic [PosW-1:0]   pos;
    logic [1:0]        ref_base;
    logic [1:0]        alt_base;
    logic [CountW-1:0] ac;
    logic [CountW-1:0] an;
    logic [LenW-1:0]   ctx_len;
    logic [CtxW-1:0]   ctx;

    logic              keep;
    logic              fold;
    logic [CountW-1:0] ac_fold;
    logic [1:0]        major;
    logic [1:0]        minor;
    logic              match;
    logic [LenW-1:0]   w_eff;
    logic              too_short;
    logic [LenW-1:0]   len_diff;
    logic [LenW-2:0]   offset;
    logic [4:0]        shamt;
    logic [CtxW-1:0]   ctx_sh;
    logic [WinW-1:0]   kmer;
    logic              bad_base;
    logic              window_ok;
    logic              load;

    logic              held_valid_reg;
    logic [PosW-1:0]   held_position_reg;
    logic [1:0]        held_major_reg;
    logic [1:0]        held_minor_reg;
    logic [CountW-1:0] held_count_reg;

    assign chrom    = in_data[9:0];
    assign pos      = in_data[40:10];
    assign ref_base = in_data[42:41];
    assign alt_base = in_data[44:43];
    assign ac       = in_data[68:45];
    assign an       = in_data[92:69];
    assign ctx_len  = in_data[96:93];
    assign ctx      = in_data[141:97];

    assign keep = in_user[0] & in_user[1] & in_user[2] & (ac != '0);

    // fold counts above half: the alternate becomes the major allele
    assign fold    = ac > (an >> 1);
    assign ac_fold = fold ? ((an >= ac) ? an - ac : '0) : ac;
    assign major   = fold ? alt_base : ref_base;
    assign minor   = fold ? ref_base : alt_base;

    assign match = held_valid_reg && (held_position_reg == pos) && (held_major_reg == major);

    assign w_eff     = (window_bases == '0) ? LenW'(1) : window_bases;
    assign too_short = ctx_len < w_eff;
    assign len_diff  = ctx_len - w_eff;
    assign offset    = len_diff[LenW-1:1];
    assign shamt     = {1'b0, offset, 1'b0} + {2'b00, offset};
    assign ctx_sh    = ctx >> shamt;

    always_comb begin
        kmer     = '0;
        bad_base = 1'b0;
        for (int i = 0; i < MaxContext; i++) begin
            if (LenW'(i) < w_eff) begin
                kmer[2*i +: 2] = ctx_sh[3*i +: 2];
                bad_base       = bad_base | ctx_sh[3*i + 2];
            end
        end
    end

    assign window_ok = !too_short && !bad_base;
    assign push      = in_accept && keep && match && window_ok;
    // a matched record with an unusable window leaves the held one in place
    assign load      = in_accept && keep && (!match || window_ok);

    always_comb begin
        job.chrom      = chrom;
        job.pos        = pos;
        job.window     = kmer;
        job.wlen       = w_eff;
        job.major      = major;
        job.minor      = minor;
        job.prev_minor = held_minor_reg;
        job.count      = ac_fold;
        job.prev_count = held_count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg    <= 1'b0;
            held_position_reg <= '0;
            held_major_reg    <= '0;
            held_minor_reg    <= '0;
            held_count_reg    <= '0;
        end else if (load) begin
            held_valid_reg    <= 1'b1;
            held_position_reg <= pos;
            held_major_reg    <= major;
            held_minor_reg    <= minor;
            held_count_reg    <= ac_fold;
        end
    end

endmodule

FILE: rtl/core/tspc_queue.sv
// ----------------------------------------------------------------------------
// tspc_queue: short job queue between front and back
// Lets the front keep taking records while the result side stalls.
// ----------------------------------------------------------------------------
module tspc_queue import tspc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  tspc_job_t push_job,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output tspc_job_t pop_job
);

    tspc_job_t       entry_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full    = count_reg == CntW'(QueueDepth);
    assign empty   = count_reg == '0;
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PtrW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("job popped from an empty queue");

    a_fill_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) && (wr_ptr_reg != rd_ptr_reg) |-> 1'b0)
        else $error("empty queue with pointers apart");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + CntW'(1))
        else $error("queue fill count did not advance on push");

endmodule

FILE: rtl/core/tspc_back.sv
// ----------------------------------------------------------------------------
// tspc_back: strand folding, window centring and slot sorting
// Takes one job per cycle from the queue into the result register if free.
// ----------------------------------------------------------------------------
module tspc_back import tspc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                empty,
    input  tspc_job_t           job,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata
);

    logic              flip;
    logic [1:0]        maj;
    logic [1:0]        minr;
    logic [1:0]        pmin;
    logic [2:0]        cen;
    logic [LenW-1:0]   wm1;
    logic [WinW-1:0]   kmer;
    logic [1:0]        ts;
    logic [1:0]        sec;
    logic [CountW-1:0] c1;
    logic [CountW-1:0] c2;
    logic [CountW-1:0] c3;

    logic                valid_reg;
    logic [OutDataW-1:0] data_reg;

    assign pop = !empty && (!valid_reg || m_tready);

    // majors G and T fold onto the opposite strand
    assign flip = job.major[1];
    assign maj  = flip ? ~job.major : job.major;
    assign minr = flip ? ~job.minor : job.minor;
    assign pmin = flip ? ~job.prev_minor : job.prev_minor;
    assign wm1  = job.wlen - LenW'(1);
    assign cen  = wm1[LenW-1:1];

    always_comb begin
        kmer = '0;
        for (int i = 0; i < MaxContext; i++) begin
            if (LenW'(i) < job.wlen) begin
                kmer[2*i +: 2] = (3'(i) == cen) ? maj
                               : (flip ? ~job.window[2*i +: 2] : job.window[2*i +: 2]);
            end
        end
    end

    assign ts  = {1'b1, maj[0]};
    assign sec = {1'b0, ~maj[0]};

    always_comb begin
        c1 = '0;
        c2 = '0;
        c3 = '0;
        if (minr == ts) begin
            c1 = job.count;
            if (pmin == sec) begin
                c2 = job.prev_count;
            end else begin
                c3 = job.prev_count;
            end
        end else if (pmin == ts) begin
            c1 = job.prev_count;
            if (minr == sec) begin
                c2 = job.count;
            end else begin
                c3 = job.count;
            end
        end else if (minr == sec) begin
            c2 = job.count;
            c3 = job.prev_count;
        end else begin
            c2 = job.prev_count;
            c3 = job.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= {c3, c2, c1, maj[0], kmer, job.pos, job.chrom};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for triallelic_site_pair_classifier
// Streams SNP records into the block, predicts each tri-allelic site from a
// behavioral copy of the pairing, folding and slot logic, and checks every
// result transfer in order. Both sides idle at random; the window register
// is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import tspc_pkg::*;

    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;
    localparam int         LONG_HOLD = 300;
    localparam int         SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [ChromW-1:0] chrom;
        logic [PosW-1:0]   pos;
        logic [1:0]        ref_b;
        logic [1:0]        alt_b;
        logic              snv;
        logic              has_counts;
        logic              has_ctx;
        logic [CountW-1:0] ac;
        logic [CountW-1:0] an;
        logic [LenW-1:0]   ctx_len;
        logic [CtxW-1:0]   ctx;
    } snp_rec_t;

    // same layout as m_tdata, first member in the top bits
    typedef struct packed {
        logic [CountW-1:0] third_cnt;
        logic [CountW-1:0] second_cnt;
        logic [CountW-1:0] transition_cnt;
        logic              major;
        logic [WinW-1:0]   window;
        logic [PosW-1:0]   pos;
        logic [ChromW-1:0] chrom;
    } tri_site_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // chrom_index, site_position, ref_base, alt_base, allele_count,
    // allele_number, context_length, context_bases, 2 zero bits
    logic [InDataW-1:0]  s_tdata = '0;
    // is_single_base, counts_present, context_present
    logic [InUserW-1:0]  s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // chrom_out, position_out, window_out, major_base_out,
    // transition_count, second_count, third_count
    logic [OutDataW-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LenW-1:0]     cfg_data = '0;

    // predictor state
    logic [LenW-1:0]   window_len = WindowReset;
    logic              kept_valid = 1'b0;
    logic [PosW-1:0]   kept_pos = '0;
    logic [1:0]        kept_major = '0;
    logic [1:0]        kept_minor = '0;
    logic [CountW-1:0] kept_count = '0;

    snp_rec_t  pending_records[$];
    tri_site_t expected_sites[$];
    snp_rec_t  on_bus;
    tri_site_t predicted;
    tri_site_t got_site;
    tri_site_t want_site;
    int        mismatches = 0;
    int        idle_pct = 15;
    int        gap_left = 0;
    int        stall_left = 0;
    int        hold_left = 0;
    logic      hold_request = 1'b0;

    triallelic_site_pair_classifier dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int eff_window();
        return (window_len == 0) ? 1 : int'(window_len);
    endfunction

    // append a record to the pending stream
    function automatic void add_record(input snp_rec_t r);
        pending_records = {pending_records, r};
    endfunction

    // Pair the record with the held one; returns 1 when a site is emitted.
    function automatic bit classify_record(input snp_rec_t r, output tri_site_t site);
        logic [CountW-1:0] cnt;
        logic [CountW-1:0] prev_cnt;
        logic [1:0]        maj;
        logic [1:0]        mnr;
        logic [1:0]        prev_mnr;
        logic [1:0]        ts;
        logic [1:0]        sec;
        logic [2:0]        b;
        logic [WinW-1:0]   kmer;
        int unsigned       w;
        int unsigned       len;
        int unsigned       off;
        int unsigned       cen;
        int unsigned       i;
        site = '0;
        if (!r.snv || !r.has_counts || r.ac == 0 || !r.has_ctx)
            return 0;
        cnt = r.ac;
        maj = r.ref_b;
        mnr = r.alt_b;
        if (r.ac > r.an / 2) begin
            cnt = (r.an >= r.ac) ? r.an - r.ac : '0;
            maj = r.alt_b;
            mnr = r.ref_b;
        end
        if (!kept_valid || kept_pos != r.pos || kept_major != maj) begin
            kept_valid = 1'b1;
            kept_pos = r.pos;
            kept_major = maj;
            kept_minor = mnr;
            kept_count = cnt;
            return 0;
        end
        w = eff_window();
        len = r.ctx_len;
        if (len > MaxContext)
            len = MaxContext;
        if (len < w)
            return 0;
        off = (len - w) / 2;
        kmer = '0;
        for (i = 0; i < w; i++) begin
            b = r.ctx[3*(off+i) +: 3];
            if (b > 3)
                return 0;
            kmer[2*i +: 2] = b[1:0];
        end
        prev_cnt = kept_count;
        prev_mnr = kept_minor;
        kept_pos = r.pos;
        kept_major = maj;
        kept_minor = mnr;
        kept_count = cnt;
        // strand-fold G/T majors onto C/A
        if (maj != BASE_A && maj != BASE_C) begin
            maj = 2'd3 - maj;
            mnr = 2'd3 - mnr;
            prev_mnr = 2'd3 - prev_mnr;
            kmer = ~kmer & WinW'((64'd1 << (2*w)) - 64'd1);
        end
        cen = (w - 1) / 2;
        kmer[2*cen +: 2] = maj;
        ts = maj + 2'd2;
        sec = maj ^ 2'd1;
        if (mnr == ts) begin
            site.transition_cnt = cnt;
            if (prev_mnr == sec) site.second_cnt = prev_cnt;
            else site.third_cnt = prev_cnt;
        end else if (prev_mnr == ts) begin
            site.transition_cnt = prev_cnt;
            if (mnr == sec) site.second_cnt = cnt;
            else site.third_cnt = cnt;
        end else if (mnr == sec) begin
            site.second_cnt = cnt;
            site.third_cnt = prev_cnt;
        end else begin
            site.second_cnt = prev_cnt;
            site.third_cnt = cnt;
        end
        site.chrom = r.chrom;
        site.pos = r.pos;
        site.window = kmer;
        site.major = maj[0];
        return 1;
    endfunction

    function automatic logic [CtxW-1:0] clean_context();
        logic [CtxW-1:0] c;
        int k;
        c = '0;
        for (k = 0; k < MaxContext; k++)
            c[3*k +: 3] = 3'($urandom_range(0, 3));
        return c;
    endfunction

    function automatic snp_rec_t site_record(input logic [PosW-1:0] pos,
                                             input logic [1:0] ref_b, input logic [1:0] alt_b,
                                             input logic [CountW-1:0] ac,
                                             input logic [CountW-1:0] an,
                                             input logic [LenW-1:0] len);
        snp_rec_t r;
        r = '0;
        r.chrom = ChromW'($urandom);
        r.pos = pos;
        r.ref_b = ref_b;
        r.alt_b = alt_b;
        r.snv = 1'b1;
        r.has_counts = 1'b1;
        r.has_ctx = 1'b1;
        r.ac = ac;
        r.an = an;
        r.ctx_len = len;
        r.ctx = clean_context();
        return r;
    endfunction

    // One record meant to fold to the given major, usually with a usable window.
    function automatic snp_rec_t make_record(input logic [PosW-1:0] pos,
                                             input logic [1:0] maj, input int w);
        snp_rec_t          r;
        logic [1:0]        mnr;
        logic [CountW-1:0] cap;
        int                sel;
        int                off;
        int                k;
        r = site_record(pos, maj, maj, 1, 2, MaxContext);
        mnr = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0: cap = 3;
            1: cap = 255;
            2: cap = 65535;
            default: cap = '1;
        endcase
        r.an = CountW'($urandom_range(2, cap));
        if ($urandom_range(0, 1) == 1) begin
            r.alt_b = mnr;
            r.ac = CountW'($urandom_range(1, r.an / 2));
        end else begin
            r.ref_b = mnr;
            if ($urandom_range(0, 9) == 0 && r.an != '1)
                r.ac = CountW'($urandom_range(r.an + 1, 24'hFFFFFF));
            else
                r.ac = CountW'($urandom_range(r.an / 2 + 1, r.an));
        end
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            r.ctx_len = LenW'($urandom_range(0, w - 1));
        end else begin
            r.ctx_len = LenW'($urandom_range(w, MaxContext));
            off = (r.ctx_len - w) / 2;
            if (sel < 18)
                r.ctx[3*(off + $urandom_range(0, w - 1)) +: 3] = 3'($urandom_range(4, 7));
        end
        // bases past the length are never looked at
        for (k = r.ctx_len; k < MaxContext; k++)
            r.ctx[3*k +: 3] = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 6) begin
            case ($urandom_range(0, 3))
                0: r.snv = 1'b0;
                1: r.has_counts = 1'b0;
                2: r.has_ctx = 1'b0;
                default: r.ac = '0;
            endcase
        end
        return r;
    endfunction

    function automatic snp_rec_t noise_record(input logic [PosW-1:0] near_pos);
        snp_rec_t r;
        r.chrom = ChromW'($urandom);
        r.pos = ($urandom_range(0, 1) == 1) ? near_pos : PosW'($urandom);
        r.ref_b = 2'($urandom);
        r.alt_b = 2'($urandom);
        {r.has_ctx, r.has_counts, r.snv} = 3'($urandom);
        r.ac = ($urandom_range(0, 3) == 0) ? '0 : CountW'($urandom);
        r.an = CountW'($urandom);
        r.ctx_len = LenW'($urandom);
        r.ctx = CtxW'({$urandom, $urandom});
        return r;
    endfunction

    task automatic queue_directed();
        snp_rec_t r;
        // nothing held yet: position 0 and major A must not pair with reset state
        add_record(site_record(0, BASE_A, BASE_G, 1, 2, 15));
        r = site_record(100, BASE_A, BASE_G, 10, 100, 15);
        r.snv = 1'b0;
        add_record(r);
        r.snv = 1'b1;
        r.has_counts = 1'b0;
        add_record(r);
        r.has_counts = 1'b1;
        r.has_ctx = 1'b0;
        add_record(r);
        r.has_ctx = 1'b1;
        r.ac = '0;
        add_record(r);
        add_record(site_record(100, BASE_A, BASE_G, 10, 100, 15));
        add_record(site_record(100, BASE_A, BASE_C, 20, 100, 15));
        add_record(site_record(100, BASE_A, BASE_T, 5, 100, 15));
        // new position, then a new major at that position
        add_record(site_record(200, BASE_A, BASE_G, 4, 9, 15));
        add_record(site_record(200, BASE_C, BASE_T, 4, 9, 15));
        // short context, then an N inside the window: both dropped
        add_record(site_record(200, BASE_C, BASE_A, 3, 50, 4));
        r = site_record(200, BASE_C, BASE_G, 3, 50, 15);
        r.ctx[3*7 +: 3] = 3'd4;
        add_record(r);
        add_record(site_record(200, BASE_C, BASE_A, 3, 50, 5));
        // count above allele number folds to zero
        add_record(site_record(300, BASE_G, BASE_A, 24'hFFFFFF, 10, 15));
        add_record(site_record(300, BASE_A, BASE_T, 1, 24'hFFFFFF, 15));
        // G and T majors are strand-folded
        add_record(site_record(400, BASE_G, BASE_A, 7, 20, 15));
        add_record(site_record(400, BASE_G, BASE_T, 9, 20, 15));
        add_record(site_record(500, BASE_T, BASE_C, 2, 6, 9));
        add_record(site_record(500, BASE_T, BASE_G, 3, 6, 15));
        // ref equal to alt
        add_record(site_record(600, BASE_C, BASE_C, 1, 4, 15));
        add_record(site_record(600, BASE_C, BASE_C, 2, 4, 15));
        // field extremes
        r = site_record(31'h7FFFFFFF, BASE_A, BASE_G, 24'h7FFFFF, 24'hFFFFFF, 15);
        r.chrom = '1;
        add_record(r);
        r = site_record(31'h7FFFFFFF, BASE_G, BASE_A, 24'hFFFFFF, 24'hFFFFFF, 15);
        r.chrom = '0;
        add_record(r);
        r = site_record(31'h7FFFFFFF, BASE_A, BASE_A, 24'hFFFFFF, 24'hFFFFFF, 0);
        r.ctx = '1;
        add_record(r);
    endtask

    task automatic queue_random(input int count);
        logic [PosW-1:0] pos;
        logic [1:0]      maj;
        int              made;
        int              n;
        int              k;
        made = 0;
        pos = PosW'($urandom);
        while (made < count) begin
            if ($urandom_range(0, 4) == 0) begin
                add_record(noise_record(pos));
                made++;
            end else begin
                if ($urandom_range(0, 3) != 0)
                    pos = PosW'($urandom);
                maj = 2'($urandom_range(0, 3));
                n = $urandom_range(2, 4);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(0, 6) == 0)
                        add_record(make_record(pos, 2'($urandom), eff_window()));
                    else
                        add_record(make_record(pos, maj, eff_window()));
                    made++;
                end
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_records.size() != 0 || s_tvalid || expected_sites.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_window(input logic [LenW-1:0] value);
        @(posedge aclk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        window_len = value;
        cfg_valid <= 1'b0;
    endtask

    int phase_window[7] = '{15, 0, 1, 4, 10, -1, 5};
    int phase_idle[7]   = '{20, 30, 0, 15, 25, 10, 0};

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        queue_directed();
        queue_random(150);
        wait_drained();
        for (int p = 0; p < 7; p++) begin
            if (phase_window[p] < 0)
                write_window(LenW'($urandom_range(0, 15)));
            else
                write_window(LenW'(phase_window[p]));
            idle_pct = phase_idle[p];
            queue_random(155);
            if (p == 1) begin
                // stall the result side while records keep coming
                @(negedge aclk);
                hold_request = 1'b1;
                @(negedge aclk);
                hold_request = 1'b0;
            end
            wait_drained();
        end
        if (mismatches == 0 && expected_sites.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // record driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (classify_record(on_bus, predicted))
                    expected_sites = {expected_sites, predicted};
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                    gap_left <= $urandom_range(0, 5);
                    s_tvalid <= 1'b0;
                end else if (pending_records.size() != 0) begin
                    on_bus = pending_records.pop_front();
                    s_tdata <= {2'b00, on_bus.ctx, on_bus.ctx_len, on_bus.an, on_bus.ac,
                                on_bus.alt_b, on_bus.ref_b, on_bus.pos, on_bus.chrom};
                    s_tuser <= {on_bus.has_ctx, on_bus.has_counts, on_bus.snv};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long result-side hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_request && hold_left == 0) begin
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_site = tri_site_t'(m_tdata);
            if (expected_sites.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected site transfer pos %0d", $realtime, got_site.pos);
            end else begin
                want_site = expected_sites.pop_front();
                if (got_site !== want_site) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: site mismatch (expected/actual) chrom %0d/%0d",
                                  " pos %0d/%0d window %h/%h major %0d/%0d",
                                  " ts %0d/%0d second %0d/%0d third %0d/%0d"},
                                 $realtime, want_site.chrom, got_site.chrom,
                                 want_site.pos, got_site.pos,
                                 want_site.window, got_site.window,
                                 want_site.major, got_site.major,
                                 want_site.transition_cnt, got_site.transition_cnt,
                                 want_site.second_cnt, got_site.second_cnt,
                                 want_site.third_cnt, got_site.third_cnt);
                end
            end
        end
    end

endmodule
